[sv/slcfp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slcfp_pkg: shared types and constants of the frame parser
// Command codes, frame layout constants, register index codes and the
// bundles passed between the parser modules.
// ----------------------------------------------------------------------------
package slcfp_pkg;

   // command codes that select the frame length
   localparam logic [7:0] CMD_BANK_WRITE   = 8'd2;
   localparam logic [7:0] CMD_CONFIG_WRITE = 8'd6;

   // frame layout
   localparam int FRAME_OVERHEAD   = 7;
   localparam int SHORT_FRAME_LEN  = 8;
   localparam int CMD_POSITION     = 2;
   localparam int SUM_START_NORMAL = 3;
   localparam int SUM_START_CONFIG = 5;

   // register reset values
   localparam logic [7:0] SYNC_FIRST_RESET  = 8'hFF;
   localparam logic [7:0] SYNC_SECOND_RESET = 8'h55;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_SYNC_FIRST  = 1'b0,
      CSR_SYNC_SECOND = 1'b1
   } csr_index_type;

   // sync pattern handed to the parser core
   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
   } sync_type;

   // one result transaction
   typedef struct packed {
      logic [8:0] byte_index;
      logic [7:0] byte_value;
      logic [7:0] frame_command;
      logic       frame_end;
      logic       checksum_ok;
   } rsp_type;

endpackage : slcfp_pkg
`default_nettype wire

[sv/slcfp_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slcfp_in_reg: input register of the frame parser
// Captures one received byte per cycle while req_stall is low and holds it
// until the parser core takes it.
// ----------------------------------------------------------------------------
module slcfp_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       take,
   output logic            held_valid,
   output logic [7:0]      held_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       load;

   // stall only while the held byte cannot move on
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   // valid bit follows loads and takes
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule : slcfp_in_reg
`default_nettype wire

[sv/slcfp_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slcfp_core: frame state and result register
// Checks sync bytes, latches the command, tracks position and running sum,
// and registers one result transaction per framed byte.
// ----------------------------------------------------------------------------
module slcfp_core #(
   parameter int BANK_PAYLOAD   = 256,
   parameter int CONFIG_PAYLOAD = 20
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire slcfp_pkg::sync_type sync,
   input  wire logic              held_valid,
   input  wire logic [7:0]        held_byte,
   output logic                   take,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output slcfp_pkg::rsp_type     rsp
);
   import slcfp_pkg::*;

   localparam int BANK_LEN   = BANK_PAYLOAD + FRAME_OVERHEAD;
   localparam int CONFIG_LEN = CONFIG_PAYLOAD + FRAME_OVERHEAD;
   localparam int LEN_MAX    = (BANK_LEN > CONFIG_LEN) ? BANK_LEN : CONFIG_LEN;
   localparam int LEN_BITS   = $clog2(LEN_MAX);
   localparam int POS_W      = (LEN_BITS > 9) ? LEN_BITS : 9;

   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [7:0]       cmd_ff;
   logic [7:0]       sum_ff;
   logic [7:0]       sum_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             out_free;
   logic             at_cmd;
   logic             past_sync;
   logic             sync_fail;
   logic [7:0]       cmd_eff;
   logic [7:0]       sum_base;
   logic [POS_W-1:0] sum_start;
   logic [POS_W-1:0] last_pos;
   logic             frame_end;

   // result register frees up when empty or taken
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = held_valid && out_free;

   // sync check on the first two positions
   assign sync_fail = ((pos_ff == POS_W'(0)) && (held_byte != sync.first)) ||
                      ((pos_ff == POS_W'(1)) && (held_byte != sync.second));

   // command and sum seen by this byte
   assign at_cmd    = (pos_ff == POS_W'(CMD_POSITION));
   assign past_sync = (pos_ff >= POS_W'(CMD_POSITION));
   assign cmd_eff   = at_cmd ? held_byte : cmd_ff;
   assign sum_base  = at_cmd ? 8'd0 : sum_ff;
   assign sum_start = (cmd_eff == CMD_CONFIG_WRITE) ? POS_W'(SUM_START_CONFIG)
                                                    : POS_W'(SUM_START_NORMAL);

   // last position of the frame from its command
   always_comb begin
      if (cmd_eff == CMD_BANK_WRITE) begin
         last_pos = POS_W'(BANK_LEN - 1);
      end else if (cmd_eff == CMD_CONFIG_WRITE) begin
         last_pos = POS_W'(CONFIG_LEN - 1);
      end else begin
         last_pos = POS_W'(SHORT_FRAME_LEN - 1);
      end
   end

   assign frame_end = past_sync && (pos_ff >= last_pos);

   // running sum over the covered bytes
   always_comb begin
      if (past_sync && (pos_ff >= sum_start)) begin
         sum_in = sum_base + held_byte;
      end else begin
         sum_in = sum_base;
      end
   end

   // next position
   assign pos_in = (sync_fail || frame_end) ? '0 : pos_ff + POS_W'(1);

   // result fields
   always_comb begin
      rsp_in.byte_index    = pos_ff[8:0];
      rsp_in.byte_value    = held_byte;
      rsp_in.frame_command = past_sync ? cmd_eff : 8'd0;
      rsp_in.frame_end     = frame_end;
      rsp_in.checksum_ok   = frame_end && (sum_in == 8'd0);
   end

   // result valid: set by a framed byte, held while stalled
   always_comb begin
      if (take) begin
         rsp_valid_in = !sync_fail;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         cmd_ff       <= 8'd0;
         sum_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            pos_ff <= pos_in;
            sum_ff <= sum_in;
            cmd_ff <= cmd_eff;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (take && !sync_fail) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef ASSERT_OFF
   a_ok_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.checksum_ok |-> rsp_ff.frame_end)
      else $error("checksum_ok without frame_end");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      take && (sync_fail || frame_end) |=> pos_ff == '0)
      else $error("position not cleared after sync failure or frame end");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(LEN_MAX - 1))
      else $error("position beyond longest frame");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      take && !sync_fail |=> rsp_valid_ff)
      else $error("framed byte produced no result");
`endif

endmodule : slcfp_core
`default_nettype wire

[sv/sync_length_checksum_frame_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_parser: byte stream frame parser
// Frames received bytes by sync pattern, command-driven length and a
// modulo-256 checksum.
// ----------------------------------------------------------------------------
// usage
//   req channel: one received byte per transaction (req_valid / req_stall)
//   rsp channel: one transaction per framed byte, with its position, the
//     latched command, frame end and checksum status (rsp_valid / rsp_stall)
//   csr port: write sync_first (index 0) or sync_second (index 1) while idle
//   bytes that break the sync pattern are dropped and give no transaction
// timing
//   one byte accepted per cycle, sustained while rsp_stall stays low; a result
//   shows on rsp once its byte has passed the input register and then the
//   result register
//   the per-byte frame update is a single pass through the core logic
// reset
//   synchronous, active high; position, command and sum clear, sync
//   registers return to 0xFF and 0x55, both channels empty
// stall
//   a stalled result holds; the input register still takes a byte if it is
//   empty, then req_stall stays high until the result is taken
// ----------------------------------------------------------------------------
module sync_length_checksum_frame_parser #(
   parameter int BANK_PAYLOAD   = 256,
   parameter int CONFIG_PAYLOAD = 20
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [8:0]      rsp_byte_index,
   output logic [7:0]      rsp_byte_value,
   output logic [7:0]      rsp_frame_command,
   output logic            rsp_frame_end,
   output logic            rsp_checksum_ok,
   input  wire logic       csr_write_enable,
   input  wire logic [0:0] csr_index,
   input  wire logic [7:0] csr_write_data
);
   import slcfp_pkg::*;

   sync_type   sync_ff;
   logic       held_valid;
   logic [7:0] held_byte;
   logic       take;
   rsp_type    rsp;

   // sync pattern registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff.first  <= SYNC_FIRST_RESET;
         sync_ff.second <= SYNC_SECOND_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SYNC_FIRST:  sync_ff.first  <= csr_write_data;
            CSR_SYNC_SECOND: sync_ff.second <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register
   slcfp_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .take        (take),
      .held_valid  (held_valid),
      .held_byte   (held_byte)
   );

   // frame state and result register
   slcfp_core #(
      .BANK_PAYLOAD   (BANK_PAYLOAD),
      .CONFIG_PAYLOAD (CONFIG_PAYLOAD)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .sync       (sync_ff),
      .held_valid (held_valid),
      .held_byte  (held_byte),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // result fields
   assign rsp_byte_index    = rsp.byte_index;
   assign rsp_byte_value    = rsp.byte_value;
   assign rsp_frame_command = rsp.frame_command;
   assign rsp_frame_end     = rsp.frame_end;
   assign rsp_checksum_ok   = rsp.checksum_ok;

endmodule : sync_length_checksum_frame_parser
`default_nettype wire
